>>> src/mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies.
package mpt_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int BOUND_BITS = 13;
  localparam int CFG_ADDR_BITS = 2;

  localparam logic [BOUND_BITS-1:0] BOUND_WIDTH_RESET = 13'd640;
  localparam logic [BOUND_BITS-1:0] BOUND_HEIGHT_RESET = 13'd480;
  localparam int CURSOR_RESET = 100;

  localparam logic [7:0] HDR_SYNC = 8'h08;
  localparam logic [7:0] HDR_X_OVF = 8'h40;
  localparam logic [7:0] HDR_Y_OVF = 8'h80;
  localparam logic [7:0] HDR_LEFT = 8'h01;
  localparam logic [7:0] HDR_RIGHT = 8'h02;
  localparam logic [7:0] HDR_MIDDLE = 8'h04;
  localparam logic signed [7:0] DELTA_POS_MAX = 8'sd127;
  localparam logic signed [7:0] DELTA_NEG_MAX = -8'sd127;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_BOUND_WIDTH = 2'd0,
    REG_BOUND_HEIGHT = 2'd1,
    REG_WHEEL_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X = 2'd1,
    PH_Y = 2'd2,
    PH_WHEEL = 2'd3
  } phase_t;

  typedef struct packed {
    logic       done;
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [3:0] wheel;
  } packet_t;

endpackage

>>> src/mpt_framer.sv
// Byte framer: tracks the byte phase and collects header and delta bytes.
// Depends on mpt_pkg.
module mpt_framer
  import mpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       wheel_mode,
  output packet_t    pkt
);

  phase_t     phase, phase_next;
  logic [7:0] header, x_byte, y_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header <= '0;
      x_byte <= '0;
      y_byte <= '0;
    end else if (step) begin
      phase <= phase_next;
      case (phase)
        PH_HEADER: begin
          if ((data_byte & HDR_SYNC) != 8'h00) header <= data_byte;
        end
        PH_X: x_byte <= data_byte;
        PH_Y: y_byte <= data_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    pkt.done = 1'b0;
    pkt.header = header;
    pkt.x_byte = x_byte;
    pkt.y_byte = y_byte;
    pkt.wheel = 4'h0;
    case (phase)
      PH_HEADER: begin
        if ((data_byte & HDR_SYNC) != 8'h00) phase_next = PH_X;
      end
      PH_X: phase_next = PH_Y;
      PH_Y: begin
        pkt.y_byte = data_byte;
        if (wheel_mode) begin
          phase_next = PH_WHEEL;
        end else begin
          phase_next = PH_HEADER;
          pkt.done = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        pkt.done = 1'b1;
        pkt.wheel = wheel_mode ? data_byte[3:0] : 4'h0;
      end
    endcase
  end

endmodule

>>> src/mpt_cursor.sv
// Cursor update and result register: applies deltas, clamps, packs the beat.
// Depends on mpt_pkg.
module mpt_cursor
  import mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int BW = 14,
  parameter int TDATA_W = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  packet_t            pkt,
  input  logic [BW-1:0]      bound_x,
  input  logic [BW-1:0]      bound_y,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [TDATA_W-1:0] m_tdata
);

  localparam int VW = COORD_BITS + 2;
  localparam int FIELD_W = 2 * COORD_BITS + 23;

  logic [COORD_BITS-1:0] cursor_x, cursor_y, pos_x_next, pos_y_next;
  logic signed [7:0]     dx, dy;
  logic signed [8:0]     dy_neg;
  logic signed [VW-1:0]  vx, vy;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [VW-1:0] v,
                                                  input logic [BW-1:0] b);
    logic [BW-1:0] bm1;
    logic [BW-1:0] vu;
    bm1 = b - BW'(1);
    vu = {{(BW-VW+1){1'b0}}, v[VW-2:0]};
    if (v[VW-1]) clamp = '0;
    else if (vu >= b) clamp = bm1[COORD_BITS-1:0];
    else clamp = v[COORD_BITS-1:0];
  endfunction

  always_comb begin
    dx = $signed(pkt.x_byte);
    if ((pkt.header & HDR_X_OVF) != 8'h00) dx = pkt.x_byte[7] ? DELTA_NEG_MAX : DELTA_POS_MAX;
    dy = $signed(pkt.y_byte);
    if ((pkt.header & HDR_Y_OVF) != 8'h00) dy = pkt.y_byte[7] ? DELTA_NEG_MAX : DELTA_POS_MAX;
    dy_neg = -{dy[7], dy};
    vx = $signed({2'b00, cursor_x}) + VW'(dx);
    vy = $signed({2'b00, cursor_y}) + VW'(dy_neg);
    pos_x_next = clamp(vx, bound_x);
    pos_y_next = clamp(vy, bound_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= COORD_BITS'(CURSOR_RESET);
      cursor_y <= COORD_BITS'(CURSOR_RESET);
      m_tvalid <= 1'b0;
    end else if (step && pkt.done) begin
      cursor_x <= pos_x_next;
      cursor_y <= pos_y_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pkt.done) begin
      m_tdata <= TDATA_W'({pkt.wheel, pkt.y_byte, pkt.x_byte,
                           (pkt.header & HDR_MIDDLE) != 8'h00,
                           (pkt.header & HDR_RIGHT) != 8'h00,
                           (pkt.header & HDR_LEFT) != 8'h00,
                           pos_y_next, pos_x_next} & {FIELD_W{1'b1}});
    end
  end

endmodule

>>> src/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: input register, config, framer, cursor.
// Depends on mpt_pkg, mpt_framer, mpt_cursor.
//
// channel  dir  width            fields
// s_*      in   8                data_byte
// m_*      out  TDATA_W          pos_x, pos_y, buttons, raw_dx, raw_dy, wheel_delta
// cfg_*    in   2 / 13           bound_width, bound_height, wheel_mode
//
// One byte per cycle while the result register can take it. A byte is held in the input
// register, then frame logic and the cursor clamp write the result register.
// rst is synchronous and resets phase, cursor (100,100), bounds (640x480) and valids.
// A stalled result holds only a byte that would complete a packet.
module ps2_mouse_packet_tracker_top
  import mpt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int TDATA_W = ((2 * COORD_BITS + 23 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // data_byte[7:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [TDATA_W-1:0]       m_tdata,   // pos_x, pos_y, button_left, button_right,
                                              // button_middle, raw_dx[8], raw_dy[8],
                                              // wheel_delta[4], zero fill
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [BOUND_BITS-1:0]    cfg_data
);

  localparam int BW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam logic [BW-1:0] LIMIT = BW'(1) << COORD_BITS;

  logic [BOUND_BITS-1:0] bound_width, bound_height;
  logic                  wheel_mode;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  step;
  packet_t               pkt;
  logic [BW-1:0]         bw_ext, bh_ext, bound_x, bound_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_width <= BOUND_WIDTH_RESET;
      bound_height <= BOUND_HEIGHT_RESET;
      wheel_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BOUND_WIDTH: if (cfg_data != '0) bound_width <= cfg_data;
        REG_BOUND_HEIGHT: if (cfg_data != '0) bound_height <= cfg_data;
        REG_WHEEL_MODE: wheel_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bw_ext = {{(BW-BOUND_BITS){1'b0}}, bound_width};
    bh_ext = {{(BW-BOUND_BITS){1'b0}}, bound_height};
    bound_x = (bw_ext > LIMIT) ? LIMIT : bw_ext;
    bound_y = (bh_ext > LIMIT) ? LIMIT : bh_ext;
  end

  assign step = in_valid && (!pkt.done || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  mpt_framer u_framer (
    .clk(clk),
    .rst(rst),
    .step(step),
    .data_byte(in_byte),
    .wheel_mode(wheel_mode),
    .pkt(pkt)
  );

  mpt_cursor #(
    .COORD_BITS(COORD_BITS),
    .BW(BW),
    .TDATA_W(TDATA_W)
  ) u_cursor (
    .clk(clk),
    .rst(rst),
    .step(step),
    .pkt(pkt),
    .bound_x(bound_x),
    .bound_y(bound_y),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata(m_tdata)
  );

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while result register free");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("valid set after reset");

  a_pos_x_in_bound: assert property (@(posedge clk) disable iff (rst)
    (step && pkt.done) |=> ({{(BW-COORD_BITS){1'b0}}, m_tdata[COORD_BITS-1:0]} < bound_x))
    else $error("pos_x outside bound");

  a_pos_y_in_bound: assert property (@(posedge clk) disable iff (rst)
    (step && pkt.done) |=>
      ({{(BW-COORD_BITS){1'b0}}, m_tdata[2*COORD_BITS-1:COORD_BITS]} < bound_y))
    else $error("pos_y outside bound");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for ps2_mouse_packet_tracker_top: random and directed PS/2 byte streams
// with sender gaps and receiver stalls, checked against a cursor predictor.
// Depends on mpt_pkg and the RTL of ps2_mouse_packet_tracker_top.
module tb_top;
  import mpt_pkg::*;

  localparam int CB = COORD_BITS_DEFAULT;
  localparam int TDATA_W = ((2 * CB + 23 + 7) / 8) * 8;
  localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_SLACK = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1650;

  // Packed so that pos_x lands in the lowest bits of tdata.
  typedef struct packed {
    logic [TDATA_W-2*CB-24:0] pad;
    logic signed [3:0]        wheel;
    logic signed [7:0]        dy;
    logic signed [7:0]        dx;
    logic                     middle;
    logic                     right;
    logic                     left;
    logic [CB-1:0]            y;
    logic [CB-1:0]            x;
  } report_t;

  class report_board;
    report_t pending[$];
    int      errors;
    int      bound_w;
    int      bound_h;
    bit      wheel_mode;
    phase_t  phase;
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [CB-1:0] cur_x;
    logic [CB-1:0] cur_y;

    function new();
      errors = 0;
      bound_w = BOUND_WIDTH_RESET;
      bound_h = BOUND_HEIGHT_RESET;
      wheel_mode = 1'b0;
      phase = PH_HEADER;
      header = '0;
      x_byte = '0;
      y_byte = '0;
      cur_x = CB'(CURSOR_RESET);
      cur_y = CB'(CURSOR_RESET);
    endfunction

    function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [BOUND_BITS-1:0] v);
      case (idx)
        REG_BOUND_WIDTH: if (v != 0) bound_w = v;
        REG_BOUND_HEIGHT: if (v != 0) bound_h = v;
        REG_WHEEL_MODE: wheel_mode = v[0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int b);
      if (b > (1 << CB)) b = 1 << CB;
      if (b == 0) b = 1;
      if (v < 0) return 0;
      if (v >= b) return b - 1;
      return v;
    endfunction

    function void finish_packet(logic [3:0] nib);
      int dx;
      int dy;
      int nx;
      int ny;
      report_t r;
      dx = $signed(x_byte);
      dy = $signed(y_byte);
      if ((header & HDR_X_OVF) != 0) dx = (dx < 0) ? DELTA_NEG_MAX : DELTA_POS_MAX;
      if ((header & HDR_Y_OVF) != 0) dy = (dy < 0) ? DELTA_NEG_MAX : DELTA_POS_MAX;
      nx = cur_x;
      ny = cur_y;
      cur_x = CB'(clamp(nx + dx, bound_w));
      cur_y = CB'(clamp(ny - dy, bound_h));
      r = '0;
      r.x = cur_x;
      r.y = cur_y;
      r.left = (header & HDR_LEFT) != 0;
      r.right = (header & HDR_RIGHT) != 0;
      r.middle = (header & HDR_MIDDLE) != 0;
      r.dx = x_byte;
      r.dy = y_byte;
      r.wheel = nib;
      pending.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PH_HEADER: begin
          if ((b & HDR_SYNC) != 0) begin
            header = b;
            phase = PH_X;
          end
        end
        PH_X: begin
          x_byte = b;
          phase = PH_Y;
        end
        PH_Y: begin
          y_byte = b;
          if (wheel_mode) begin
            phase = PH_WHEEL;
          end else begin
            phase = PH_HEADER;
            finish_packet(4'd0);
          end
        end
        default: begin
          phase = PH_HEADER;
          finish_packet(wheel_mode ? b[3:0] : 4'd0);
        end
      endcase
    endfunction

    function void field_check(string nm, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", nm, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [TDATA_W-1:0] d);
      report_t got;
      report_t want;
      got = d;
      if (pending.size() == 0) begin
        $error("report with none expected: tdata %h", d);
        errors++;
        return;
      end
      want = pending.pop_front();
      field_check("pos_x", want.x, got.x);
      field_check("pos_y", want.y, got.y);
      field_check("button_left", want.left, got.left);
      field_check("button_right", want.right, got.right);
      field_check("button_middle", want.middle, got.middle);
      field_check("raw_dx", want.dx, got.dx);
      field_check("raw_dy", want.dy, got.dy);
      field_check("wheel_delta", want.wheel, got.wheel);
      field_check("zero_fill", want.pad, got.pad);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [BOUND_BITS-1:0] cfg_data;

  report_board board;
  int cycle_count;
  int burst_left;
  int items_sent;
  bit calm;
  bit ready_free;
  logic [15:0] stall_pat;
  int pat_age;

  ps2_mouse_packet_tracker_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ps2_mouse_packet_tracker_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.take_byte(s_tdata);
      if (m_tvalid && m_tready) board.check_report(m_tdata);
    end
  end

  // receiver stalls follow a rotating mask that is renewed with a random value
  always @(negedge clk) begin
    m_tready <= ready_free || stall_pat[0];
    pat_age <= pat_age + 1;
    if (pat_age % 64 == 63) stall_pat <= 16'($urandom);
    else stall_pat <= {stall_pat[0], stall_pat[15:1]};
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      if (!calm) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tdata <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [BOUND_BITS-1:0] v);
    cfg_addr <= idx;
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
    @(negedge clk);
  endtask

  function automatic logic [BOUND_BITS-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0: return 13'd1;
      1: return 13'd2;
      2: return 13'd4095;
      3: return 13'd4096;
      4: return 13'd4097;
      5: return 13'd8191;
      6: return 13'd0;
      7: return 13'($urandom_range(1, 8191));
      default: return 13'($urandom_range(1, 700));
    endcase
  endfunction

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 5))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'($urandom_range(0, 8)) - 8'd4;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_header();
    logic [7:0] h;
    h = 8'($urandom) | HDR_SYNC;
    if ($urandom_range(0, 1)) h = h & ~(HDR_X_OVF | HDR_Y_OVF);
    return h;
  endfunction

  task automatic send_packet(input int len);
    send_byte(pick_header());
    items_sent++;
    if (len > 1) begin
      send_byte(pick_delta());
      items_sent++;
    end
    if (len > 2) begin
      send_byte(pick_delta());
      items_sent++;
    end
    if (len > 3) begin
      send_byte(8'($urandom));
      items_sent++;
    end
  endtask

  task automatic run_phase(input int n_packets);
    int r;
    for (int i = 0; i < n_packets; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_byte(8'($urandom));
      else if (r < 14) send_packet($urandom_range(1, 2));
      else send_packet(board.wheel_mode ? 4 : 3);
    end
    // leave the framer mid-packet now and then, so the next setup lands there
    if ($urandom_range(0, 1)) send_packet($urandom_range(1, 3));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    cycle_count = 0;
    burst_left = 0;
    items_sent = 0;
    calm = 1'b0;
    ready_free = 1'b0;
    stall_pat = 16'hB5A3;
    pat_age = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset bounds, dropped non-sync bytes, overflow forcing, buttons
    send_byte(8'h00);
    send_byte(8'hF7);
    send_byte(8'h08); send_byte(8'h7F); send_byte(8'h80);
    send_byte(8'hCF); send_byte(8'h80); send_byte(8'h01);
    send_byte(8'h48); send_byte(8'h05); send_byte(8'hFF);
    send_byte(8'h8A); send_byte(8'h00); send_byte(8'hFE);
    wait_idle();
    write_reg(REG_WHEEL_MODE, 13'd1);
    send_byte(8'h09); send_byte(8'h01); send_byte(8'h02); send_byte(8'h0F);
    send_byte(8'h0E); send_byte(8'hFE); send_byte(8'h03); send_byte(8'hF7);
    send_byte(8'h28); send_byte(8'h01); send_byte(8'h02);
    // wheel mode dropped while the fourth byte is still due
    wait_idle();
    write_reg(REG_WHEEL_MODE, 13'd0);
    send_byte(8'hF5);
    send_byte(8'h0B); send_byte(8'h04);
    // wheel mode raised after the x byte
    wait_idle();
    write_reg(REG_WHEEL_MODE, 13'd1);
    send_byte(8'h05); send_byte(8'h0C);
    wait_idle();
    write_reg(REG_BOUND_WIDTH, 13'd0);
    write_reg(REG_BOUND_HEIGHT, 13'd8191);
    write_reg(REG_BOUND_WIDTH, 13'd1);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_byte(8'h08); send_byte(8'h7F); send_byte(8'h80); send_byte(8'h08);

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      ready_free = calm || ($urandom_range(0, 5) == 0);
      write_reg(REG_BOUND_WIDTH, pick_bound());
      write_reg(REG_BOUND_HEIGHT, pick_bound());
      write_reg(REG_WHEEL_MODE, 13'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 13'($urandom));
      run_phase($urandom_range(20, 60));
    end

    wait_idle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS ps2_mouse_packet_tracker_top");
    end else begin
      $display("FAIL ps2_mouse_packet_tracker_top");
    end
    $finish;
  end
endmodule
